@@ hw/rtl/hbox_pkg.sv @@
// Package for the hand box pipeline: fixed-point widths, image bound and clamp helpers.
// Used by hand_box_from_arm_joints; depends on nothing else.

package hbox_pkg;

   localparam int FRAC_BITS = 4;
   localparam int IN_W      = 16;
   localparam int VIS_W     = 2;
   localparam int DIM_W     = 12;
   localparam int MAX_DIM   = 2048;
   localparam int DIM_IDX_W = $clog2(MAX_DIM);

   // corner points carry FRAC_BITS+2 fraction bits, centred square one more
   localparam int DIFF_W = IN_W + 1;
   localparam int PT_W   = IN_W + 5;
   localparam int BND_W  = DIM_IDX_W + FRAC_BITS + 2;
   localparam int SUM_W  = BND_W + 1;
   localparam int CLP_W  = ((PT_W > BND_W) ? PT_W : BND_W) + 1;
   localparam int POS_W  = SUM_W - 3;
   localparam int OUT_W  = 15;
   localparam int SIDE_W = POS_W - FRAC_BITS;
   localparam int AREA_W = 2 * SIDE_W;
   localparam int ASP_W  = POS_W + 3;

   localparam int CFG_W = 23;
   localparam logic [CFG_W-1:0] MIN_AREA_RESET = CFG_W'(1024);
   localparam int AC_W  = (AREA_W > CFG_W) ? AREA_W : CFG_W;

   localparam logic [VIS_W-1:0] VIS_USABLE_MAX = VIS_W'(1);

   // last valid pixel coordinate of an image dimension, at corner scale
   function automatic logic [BND_W-1:0] dim_bound(input logic [DIM_W-1:0] dim);
      logic [DIM_IDX_W-1:0] last;
      if (dim == '0) begin
         last = '0;
      end else if (dim > DIM_W'(MAX_DIM)) begin
         last = DIM_IDX_W'(MAX_DIM - 1);
      end else begin
         last = DIM_IDX_W'(dim - DIM_W'(1));
      end
      return BND_W'(last) << (FRAC_BITS + 2);
   endfunction

   function automatic logic [BND_W-1:0] clamp_pt(input logic signed [PT_W-1:0] v,
                                                 input logic [BND_W-1:0]       hi);
      logic signed [CLP_W-1:0] ve;
      logic signed [CLP_W-1:0] he;
      ve = {{(CLP_W-PT_W){v[PT_W-1]}}, v};
      he = {{(CLP_W-BND_W){1'b0}}, hi};
      if (ve < 0) begin
         return '0;
      end else if (ve > he) begin
         return hi;
      end else begin
         return ve[BND_W-1:0];
      end
   endfunction

   function automatic logic [SUM_W-1:0] clamp_sum(input logic signed [SUM_W+1:0] v,
                                                  input logic [SUM_W-1:0]        hi);
      logic signed [SUM_W+1:0] he;
      he = {2'b00, hi};
      if (v < 0) begin
         return '0;
      end else if (v > he) begin
         return hi;
      end else begin
         return v[SUM_W-1:0];
      end
   endfunction

endpackage

@@ hw/rtl/hand_box_from_arm_joints.sv @@
// Hand box pipeline: square hand box beyond the wrist of one arm.
// Depends on hbox_pkg for widths, the image bound and the clamp helpers.

// The block takes one arm per cycle while req_stall is low and returns one box per arm,
// in order. The box passes through the register stages and the output register to the
// rsp ports, and it can leave at the next edge when the result side does not stall.
// The work runs through five register stages (differences, corners, min/max with
// clamp, span and centre, square clamp) and the output register, which holds the
// area multiply and aspect compares. Empty stages fill while the output stalls,
// so a stall costs no throughput until all stages hold a request; req_stall follows
// rsp_stall through the stage enables in the same cycle. min_area is written through
// the csr port, which is always ready; it resets to 1024.
module hand_box_from_arm_joints
   import hbox_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [IN_W-1:0]  req_elbow_x,
   input  logic signed [IN_W-1:0]  req_elbow_y,
   input  logic signed [IN_W-1:0]  req_wrist_x,
   input  logic signed [IN_W-1:0]  req_wrist_y,
   input  logic [VIS_W-1:0]        req_elbow_vis,
   input  logic [VIS_W-1:0]        req_wrist_vis,
   input  logic [DIM_W-1:0]        req_image_width,
   input  logic [DIM_W-1:0]        req_image_height,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_box_found,
   output logic [OUT_W-1:0]        rsp_box_left,
   output logic [OUT_W-1:0]        rsp_box_top,
   output logic [OUT_W-1:0]        rsp_box_right,
   output logic [OUT_W-1:0]        rsp_box_bottom,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CFG_W-1:0]        csr_min_area
);

   // ---------------------------------------------------------------- config
   logic [CFG_W-1:0] min_area_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_area_ff <= MIN_AREA_RESET;
      end else if (csr_valid && csr_ready) begin
         min_area_ff <= csr_min_area;
      end
   end

   // ---------------------------------------------------------------- flow control
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, rsp_vld_ff;
   logic s1_adv, s2_adv, s3_adv, s4_adv, s5_adv, out_adv;

   // a stage loads when it is empty or its contents move on
   assign out_adv = !rsp_vld_ff || !rsp_stall;
   assign s5_adv  = !s5_vld_ff  || out_adv;
   assign s4_adv  = !s4_vld_ff  || s5_adv;
   assign s3_adv  = !s3_vld_ff  || s4_adv;
   assign s2_adv  = !s2_vld_ff  || s3_adv;
   assign s1_adv  = !s1_vld_ff  || s2_adv;

   assign req_stall = !s1_adv;
   assign rsp_valid = rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (s1_adv)  s1_vld_ff  <= req_valid;
         if (s2_adv)  s2_vld_ff  <= s1_vld_ff;
         if (s3_adv)  s3_vld_ff  <= s2_vld_ff;
         if (s4_adv)  s4_vld_ff  <= s3_vld_ff;
         if (s5_adv)  s5_vld_ff  <= s4_vld_ff;
         if (out_adv) rsp_vld_ff <= s5_vld_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // usable flag, arm direction, image bounds
   logic                     s1_ok_in, s1_ok_ff;
   logic signed [IN_W-1:0]   s1_wx_ff, s1_wy_ff;
   logic signed [DIFF_W-1:0] s1_dx_in, s1_dy_in, s1_dx_ff, s1_dy_ff;
   logic [BND_W-1:0]         s1_hx_in, s1_hy_in, s1_hx_ff, s1_hy_ff;

   always_comb begin
      s1_dx_in = {req_wrist_x[IN_W-1], req_wrist_x} - {req_elbow_x[IN_W-1], req_elbow_x};
      s1_dy_in = {req_wrist_y[IN_W-1], req_wrist_y} - {req_elbow_y[IN_W-1], req_elbow_y};
      s1_ok_in = (req_elbow_vis <= VIS_USABLE_MAX) && (req_wrist_vis <= VIS_USABLE_MAX)
                 && !((req_wrist_x == req_elbow_x) && (req_wrist_y == req_elbow_y));
      s1_hx_in = dim_bound(req_image_width);
      s1_hy_in = dim_bound(req_image_height);
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_ok_ff <= s1_ok_in;
         s1_wx_ff <= req_wrist_x;
         s1_wy_ff <= req_wrist_y;
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
         s1_hx_ff <= s1_hx_in;
         s1_hy_ff <= s1_hy_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // four square corners at corner scale
   logic                   s2_ok_ff;
   logic [BND_W-1:0]       s2_hx_ff, s2_hy_ff;
   logic signed [PT_W-1:0] wx4, wy4, dx2, dy2, dx4, dy4;
   logic signed [PT_W-1:0] s2_p1x_in, s2_p1y_in, s2_p2x_in, s2_p2y_in;
   logic signed [PT_W-1:0] s2_p3x_in, s2_p3y_in, s2_p4x_in, s2_p4y_in;
   logic signed [PT_W-1:0] s2_p1x_ff, s2_p1y_ff, s2_p2x_ff, s2_p2y_ff;
   logic signed [PT_W-1:0] s2_p3x_ff, s2_p3y_ff, s2_p4x_ff, s2_p4y_ff;

   always_comb begin
      wx4 = {{(PT_W-IN_W){s1_wx_ff[IN_W-1]}}, s1_wx_ff} <<< 2;
      wy4 = {{(PT_W-IN_W){s1_wy_ff[IN_W-1]}}, s1_wy_ff} <<< 2;
      dx2 = {{(PT_W-DIFF_W){s1_dx_ff[DIFF_W-1]}}, s1_dx_ff} <<< 1;
      dy2 = {{(PT_W-DIFF_W){s1_dy_ff[DIFF_W-1]}}, s1_dy_ff} <<< 1;
      dx4 = dx2 <<< 1;
      dy4 = dy2 <<< 1;
      s2_p1x_in = wx4 + dy2;
      s2_p1y_in = wy4 - dx2;
      s2_p2x_in = wx4 - dy2;
      s2_p2y_in = wy4 + dx2;
      s2_p3x_in = s2_p1x_in + dx4;
      s2_p3y_in = s2_p1y_in + dy4;
      s2_p4x_in = s2_p2x_in + dx4;
      s2_p4y_in = s2_p2y_in + dy4;
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_ok_ff  <= s1_ok_ff;
         s2_hx_ff  <= s1_hx_ff;
         s2_hy_ff  <= s1_hy_ff;
         s2_p1x_ff <= s2_p1x_in;
         s2_p1y_ff <= s2_p1y_in;
         s2_p2x_ff <= s2_p2x_in;
         s2_p2y_ff <= s2_p2y_in;
         s2_p3x_ff <= s2_p3x_in;
         s2_p3y_ff <= s2_p3y_in;
         s2_p4x_ff <= s2_p4x_in;
         s2_p4y_ff <= s2_p4y_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // bounding box of the corners, clamped to the image
   logic                   s3_ok_ff;
   logic [BND_W-1:0]       s3_hx_ff, s3_hy_ff;
   logic signed [PT_W-1:0] xa_lo, xb_lo, xa_hi, xb_hi, ya_lo, yb_lo, ya_hi, yb_hi;
   logic signed [PT_W-1:0] xlo, xhi, ylo, yhi;
   logic [BND_W-1:0]       s3_xmin_in, s3_xmax_in, s3_ymin_in, s3_ymax_in;
   logic [BND_W-1:0]       s3_xmin_ff, s3_xmax_ff, s3_ymin_ff, s3_ymax_ff;

   always_comb begin
      xa_lo = (s2_p1x_ff < s2_p2x_ff) ? s2_p1x_ff : s2_p2x_ff;
      xb_lo = (s2_p3x_ff < s2_p4x_ff) ? s2_p3x_ff : s2_p4x_ff;
      xa_hi = (s2_p1x_ff > s2_p2x_ff) ? s2_p1x_ff : s2_p2x_ff;
      xb_hi = (s2_p3x_ff > s2_p4x_ff) ? s2_p3x_ff : s2_p4x_ff;
      ya_lo = (s2_p1y_ff < s2_p2y_ff) ? s2_p1y_ff : s2_p2y_ff;
      yb_lo = (s2_p3y_ff < s2_p4y_ff) ? s2_p3y_ff : s2_p4y_ff;
      ya_hi = (s2_p1y_ff > s2_p2y_ff) ? s2_p1y_ff : s2_p2y_ff;
      yb_hi = (s2_p3y_ff > s2_p4y_ff) ? s2_p3y_ff : s2_p4y_ff;
      xlo = (xa_lo < xb_lo) ? xa_lo : xb_lo;
      xhi = (xa_hi > xb_hi) ? xa_hi : xb_hi;
      ylo = (ya_lo < yb_lo) ? ya_lo : yb_lo;
      yhi = (ya_hi > yb_hi) ? ya_hi : yb_hi;
      s3_xmin_in = clamp_pt(xlo, s2_hx_ff);
      s3_xmax_in = clamp_pt(xhi, s2_hx_ff);
      s3_ymin_in = clamp_pt(ylo, s2_hy_ff);
      s3_ymax_in = clamp_pt(yhi, s2_hy_ff);
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_ok_ff   <= s2_ok_ff;
         s3_hx_ff   <= s2_hx_ff;
         s3_hy_ff   <= s2_hy_ff;
         s3_xmin_ff <= s3_xmin_in;
         s3_xmax_ff <= s3_xmax_in;
         s3_ymin_ff <= s3_ymin_in;
         s3_ymax_ff <= s3_ymax_in;
      end
   end

   // ---------------------------------------------------------------- stage 4
   // square side and doubled centre
   logic             s4_ok_ff;
   logic [BND_W-1:0] s4_hx_ff, s4_hy_ff;
   logic [BND_W-1:0] span_x, span_y;
   logic [BND_W-1:0] s4_wh_in, s4_wh_ff;
   logic [SUM_W-1:0] s4_sx_in, s4_sy_in, s4_sx_ff, s4_sy_ff;

   always_comb begin
      span_x   = s3_xmax_ff - s3_xmin_ff;
      span_y   = s3_ymax_ff - s3_ymin_ff;
      s4_wh_in = (span_x > span_y) ? span_x : span_y;
      s4_sx_in = {1'b0, s3_xmin_ff} + {1'b0, s3_xmax_ff};
      s4_sy_in = {1'b0, s3_ymin_ff} + {1'b0, s3_ymax_ff};
   end

   always_ff @(posedge clock) begin
      if (s4_adv) begin
         s4_ok_ff <= s3_ok_ff;
         s4_hx_ff <= s3_hx_ff;
         s4_hy_ff <= s3_hy_ff;
         s4_wh_ff <= s4_wh_in;
         s4_sx_ff <= s4_sx_in;
         s4_sy_ff <= s4_sy_in;
      end
   end

   // ---------------------------------------------------------------- stage 5
   // centred square, clamped again, rounded down to output scale
   logic                    s5_ok_ff;
   logic signed [SUM_W+1:0] whe, sxe, sye;
   logic [SUM_W-1:0]        hx2, hy2;
   logic [SUM_W-1:0]        cl_l, cl_r, cl_t, cl_b;
   logic [POS_W-1:0]        s5_l_in, s5_r_in, s5_t_in, s5_b_in;
   logic [POS_W-1:0]        s5_l_ff, s5_r_ff, s5_t_ff, s5_b_ff;

   always_comb begin
      whe  = {3'b000, s4_wh_ff};
      sxe  = {2'b00, s4_sx_ff};
      sye  = {2'b00, s4_sy_ff};
      hx2  = {s4_hx_ff, 1'b0};
      hy2  = {s4_hy_ff, 1'b0};
      cl_l = clamp_sum(sxe - whe, hx2);
      cl_r = clamp_sum(sxe + whe, hx2);
      cl_t = clamp_sum(sye - whe, hy2);
      cl_b = clamp_sum(sye + whe, hy2);
      s5_l_in = cl_l[SUM_W-1:3];
      s5_r_in = cl_r[SUM_W-1:3];
      s5_t_in = cl_t[SUM_W-1:3];
      s5_b_in = cl_b[SUM_W-1:3];
   end

   always_ff @(posedge clock) begin
      if (s5_adv) begin
         s5_ok_ff <= s4_ok_ff;
         s5_l_ff  <= s5_l_in;
         s5_r_ff  <= s5_r_in;
         s5_t_ff  <= s5_t_in;
         s5_b_ff  <= s5_b_in;
      end
   end

   // ---------------------------------------------------------------- output
   // aspect and area tests, zero the box when rejected
   logic [POS_W-1:0]  box_w, box_h;
   logic [ASP_W-1:0]  w5, w6, h5, h6;
   logic [AREA_W-1:0] area;
   logic              aspect_ok, area_ok, found_in;
   logic              found_ff;
   logic [OUT_W-1:0]  left_in, top_in, right_in, bottom_in;
   logic [OUT_W-1:0]  left_ff, top_ff, right_ff, bottom_ff;

   always_comb begin
      box_w     = s5_r_ff - s5_l_ff;
      box_h     = s5_b_ff - s5_t_ff;
      w5        = ASP_W'(box_w) * ASP_W'(5);
      w6        = ASP_W'(box_w) * ASP_W'(6);
      h5        = ASP_W'(box_h) * ASP_W'(5);
      h6        = ASP_W'(box_h) * ASP_W'(6);
      aspect_ok = (w6 > h5) && (w5 < h6);
      area      = AREA_W'(box_w[POS_W-1:FRAC_BITS]) * AREA_W'(box_h[POS_W-1:FRAC_BITS]);
      area_ok   = AC_W'(area) > AC_W'(min_area_ff);
      found_in  = s5_ok_ff && aspect_ok && area_ok;
      left_in   = found_in ? OUT_W'(s5_l_ff) : '0;
      top_in    = found_in ? OUT_W'(s5_t_ff) : '0;
      right_in  = found_in ? OUT_W'(s5_r_ff) : '0;
      bottom_in = found_in ? OUT_W'(s5_b_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         found_ff  <= found_in;
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
      end
   end

   assign rsp_box_found  = found_ff;
   assign rsp_box_left   = left_ff;
   assign rsp_box_top    = top_ff;
   assign rsp_box_right  = right_ff;
   assign rsp_box_bottom = bottom_ff;

endmodule

@@ test/tb_hand_box_from_arm_joints.sv @@
// Testbench for hand_box_from_arm_joints: table of directed arms, then random arms in phases
// with varied min_area; each box checked against a typed box or an in-bench predictor.
// Depends on hbox_pkg and the hand_box_from_arm_joints RTL only.

module tb_hand_box_from_arm_joints;
   timeunit 1ns;
   timeprecision 1ps;

   import hbox_pkg::*;

   typedef struct packed {
      logic signed [IN_W-1:0] elbow_x;
      logic signed [IN_W-1:0] elbow_y;
      logic signed [IN_W-1:0] wrist_x;
      logic signed [IN_W-1:0] wrist_y;
      logic [VIS_W-1:0]       elbow_vis;
      logic [VIS_W-1:0]       wrist_vis;
      logic [DIM_W-1:0]       image_width;
      logic [DIM_W-1:0]       image_height;
   } arm_type;

   typedef struct packed {
      logic             found;
      logic [OUT_W-1:0] left;
      logic [OUT_W-1:0] top;
      logic [OUT_W-1:0] right;
      logic [OUT_W-1:0] bottom;
   } box_type;

   // typed = 1: the box in the row is the answer, otherwise the predictor supplies it
   typedef struct packed {
      arm_type arm;
      logic    typed;
      box_type want;
   } arm_row_type;

   localparam int N_DIR = 17;
   localparam arm_row_type DIR_ROWS [N_DIR] = '{
      // arm straight down, 100 px long: square 100 px below the wrist
      '{'{1600, 1600, 1600, 3200, 0, 0, 1000, 1000}, 1'b1, '{1'b1, 800, 3200, 2400, 4800}},
      '{'{1600, 1600, 1600, 3200, 2, 0, 1000, 1000}, 1'b1, '0},
      '{'{1600, 1600, 1600, 3200, 1, 3, 1000, 1000}, 1'b1, '0},
      // wrist on the elbow
      '{'{4000, 4000, 4000, 4000, 0, 1, 1000, 1000}, 1'b1, '0},
      // one-pixel image height leaves no height at all
      '{'{1600, 1600, 1600, 3200, 0, 0, 1000, 1}, 1'b1, '0},
      // zero image width acts as one pixel
      '{'{1600, 1600, 1600, 3200, 0, 0, 0, 1000}, 1'b1, '0},
      // 32 x 32 px box: area equals the reset threshold, not above it
      '{'{1600, 1600, 1600, 2112, 0, 0, 1000, 1000}, 1'b1, '0},
      '{'{1600, 1600, 1600, 2128, 0, 0, 1000, 1000}, 1'b0, '0},
      '{'{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 0, 0, 2048, 2048}, 1'b0, '0},
      '{'{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1, 1, 2048, 2048}, 1'b0, '0},
      // oversized image clips to the largest size
      '{'{16000, 16000, 16800, 16800, 1, 1, 4095, 4095}, 1'b0, '0},
      '{'{16000, 16000, 20000, 16000, 0, 0, 2048, 2048}, 1'b0, '0},
      '{'{30000, 30000, 32000, 31000, 0, 0, 2048, 2048}, 1'b0, '0},
      '{'{800, 800, 0, 0, 0, 0, 640, 480}, 1'b0, '0},
      '{'{5000, 3000, 4000, 5000, 1, 0, 640, 480}, 1'b0, '0},
      '{'{1600, 1600, 1600, 3200, 3, 3, 4095, 0}, 1'b1, '0},
      '{'{-100, -200, 300, -400, 0, 0, 1, 1}, 1'b1, '0}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic signed [IN_W-1:0] req_elbow_x;
   logic signed [IN_W-1:0] req_elbow_y;
   logic signed [IN_W-1:0] req_wrist_x;
   logic signed [IN_W-1:0] req_wrist_y;
   logic [VIS_W-1:0]       req_elbow_vis;
   logic [VIS_W-1:0]       req_wrist_vis;
   logic [DIM_W-1:0]       req_image_width;
   logic [DIM_W-1:0]       req_image_height;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_box_found;
   logic [OUT_W-1:0]       rsp_box_left;
   logic [OUT_W-1:0]       rsp_box_top;
   logic [OUT_W-1:0]       rsp_box_right;
   logic [OUT_W-1:0]       rsp_box_bottom;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_min_area;

   box_type          pending_boxes [$];
   logic [CFG_W-1:0] min_area_now;
   int               box_errors = 0;
   int               stall_left = 0;
   int               rsp_hold_left = 0;
   bit               hold_req = 1'b0;
   bit               snd_burst = 1'b0;
   bit               rsp_burst = 1'b0;

   hand_box_from_arm_joints uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_elbow_x      (req_elbow_x),
      .req_elbow_y      (req_elbow_y),
      .req_wrist_x      (req_wrist_x),
      .req_wrist_y      (req_wrist_y),
      .req_elbow_vis    (req_elbow_vis),
      .req_wrist_vis    (req_wrist_vis),
      .req_image_width  (req_image_width),
      .req_image_height (req_image_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_box_found    (rsp_box_found),
      .rsp_box_left     (rsp_box_left),
      .rsp_box_top      (rsp_box_top),
      .rsp_box_right    (rsp_box_right),
      .rsp_box_bottom   (rsp_box_bottom),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_min_area     (csr_min_area)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint clip(input longint v, input longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   // last pixel of an image dimension, at corner scale (two extra fraction bits)
   function automatic longint last_px(input logic [DIM_W-1:0] dim);
      longint n;
      n = longint'(dim);
      if (n < 1) n = 1;
      if (n > MAX_DIM) n = MAX_DIM;
      return (n - 1) <<< (FRAC_BITS + 2);
   endfunction

   function automatic box_type predict_box(input arm_type a);
      longint  ex, ey, wx, wy, dx, dy, bx, by;
      longint  px [4];
      longint  py [4];
      longint  x0, x1, y0, y1, span, l, t, r, b, w, h;
      box_type o;
      o = '0;
      if (a.elbow_vis > VIS_USABLE_MAX || a.wrist_vis > VIS_USABLE_MAX) return o;
      ex = longint'($signed(a.elbow_x));
      ey = longint'($signed(a.elbow_y));
      wx = longint'($signed(a.wrist_x));
      wy = longint'($signed(a.wrist_y));
      dx = wx - ex;
      dy = wy - ey;
      if (dx == 0 && dy == 0) return o;
      bx = last_px(a.image_width);
      by = last_px(a.image_height);
      // corners at scale 4: wrist +/- half the perpendicular, then pushed out by d
      px[0] = 4 * wx + 2 * dy;  py[0] = 4 * wy - 2 * dx;
      px[1] = 4 * wx - 2 * dy;  py[1] = 4 * wy + 2 * dx;
      px[2] = px[0] + 4 * dx;   py[2] = py[0] + 4 * dy;
      px[3] = px[1] + 4 * dx;   py[3] = py[1] + 4 * dy;
      x0 = px[0]; x1 = px[0]; y0 = py[0]; y1 = py[0];
      for (int i = 1; i < 4; i++) begin
         if (px[i] < x0) x0 = px[i];
         if (px[i] > x1) x1 = px[i];
         if (py[i] < y0) y0 = py[i];
         if (py[i] > y1) y1 = py[i];
      end
      x0 = clip(x0, bx);
      x1 = clip(x1, bx);
      y0 = clip(y0, by);
      y1 = clip(y1, by);
      // centred square at scale 8, floored back to the output scale
      span = (x1 - x0 > y1 - y0) ? x1 - x0 : y1 - y0;
      l = clip(x0 + x1 - span, 2 * bx) >>> 3;
      r = clip(x0 + x1 + span, 2 * bx) >>> 3;
      t = clip(y0 + y1 - span, 2 * by) >>> 3;
      b = clip(y0 + y1 + span, 2 * by) >>> 3;
      w = r - l;
      h = b - t;
      if (6 * w > 5 * h && 5 * w < 6 * h &&
          (w >>> FRAC_BITS) * (h >>> FRAC_BITS) > longint'(min_area_now)) begin
         o.found  = 1'b1;
         o.left   = l[OUT_W-1:0];
         o.top    = t[OUT_W-1:0];
         o.right  = r[OUT_W-1:0];
         o.bottom = b[OUT_W-1:0];
      end
      return o;
   endfunction

   function automatic logic signed [IN_W-1:0] sat_coord(input int v);
      if (v < -32768) return 16'sh8000;
      if (v > 32767) return 16'sh7FFF;
      return IN_W'(v);
   endfunction

   // mostly a sane arm inside the image; one in five is raw noise
   function automatic arm_type draw_arm();
      arm_type a;
      int      iw, ih, ex, ey, dx, dy;
      if ($urandom_range(0, 4) == 0) begin
         a.elbow_x      = IN_W'($urandom);
         a.elbow_y      = IN_W'($urandom);
         a.wrist_x      = IN_W'($urandom);
         a.wrist_y      = IN_W'($urandom);
         a.elbow_vis    = VIS_W'($urandom);
         a.wrist_vis    = VIS_W'($urandom);
         a.image_width  = DIM_W'($urandom);
         a.image_height = DIM_W'($urandom);
         return a;
      end
      iw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : $urandom_range(200, MAX_DIM);
      ih = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : $urandom_range(200, MAX_DIM);
      ex = $urandom_range(0, (iw << FRAC_BITS) - 1);
      ey = $urandom_range(0, (ih << FRAC_BITS) - 1);
      dx = int'($urandom_range(0, 3000)) - 1500;
      dy = int'($urandom_range(0, 3000)) - 1500;
      if ($urandom_range(0, 29) == 0) begin
         dx = 0;
         dy = 0;
      end
      a.elbow_x      = sat_coord(ex);
      a.elbow_y      = sat_coord(ey);
      a.wrist_x      = sat_coord(ex + dx);
      a.wrist_y      = sat_coord(ey + dy);
      a.elbow_vis    = ($urandom_range(0, 7) == 0) ? VIS_W'($urandom_range(2, 3))
                                                   : VIS_W'($urandom_range(0, 1));
      a.wrist_vis    = ($urandom_range(0, 7) == 0) ? VIS_W'($urandom_range(2, 3))
                                                   : VIS_W'($urandom_range(0, 1));
      a.image_width  = DIM_W'(iw);
      a.image_height = DIM_W'(ih);
      return a;
   endfunction

   task automatic report_bad(input string field, input longint got, input longint want);
      $display("%0t ns: box mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
      box_errors++;
   endtask

   // called at a falling edge, returns at a falling edge with the request accepted
   task automatic send_arm(input arm_type a, input box_type want);
      int gap;
      gap = snd_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_elbow_x      = a.elbow_x;
      req_elbow_y      = a.elbow_y;
      req_wrist_x      = a.wrist_x;
      req_wrist_y      = a.wrist_y;
      req_elbow_vis    = a.elbow_vis;
      req_wrist_vis    = a.wrist_vis;
      req_image_width  = a.image_width;
      req_image_height = a.image_height;
      req_valid        = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_boxes = {pending_boxes, want};
      @(negedge clock);
   endtask

   task automatic write_min_area(input logic [CFG_W-1:0] v);
      csr_min_area = v;
      csr_valid    = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      min_area_now = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // result side: one long hold when asked, and outside burst phases a drawn stall after each box
   initial begin
      bit took;
      bit hold_seen;
      took      = 1'b0;
      hold_seen = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         took = !reset && rsp_valid && !rsp_stall;
         @(negedge clock);
         if (took) stall_left = rsp_burst ? 0 : $urandom_range(0, 13);
         if (hold_req && !hold_seen) begin
            hold_seen     = 1'b1;
            rsp_hold_left = 300;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      box_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_boxes.size() == 0) begin
            report_bad("box with no request", rsp_box_found, 0);
         end else begin
            want = pending_boxes.pop_front();
            if (rsp_box_found !== want.found) report_bad("found", rsp_box_found, want.found);
            if (rsp_box_left !== want.left) report_bad("left", rsp_box_left, want.left);
            if (rsp_box_top !== want.top) report_bad("top", rsp_box_top, want.top);
            if (rsp_box_right !== want.right) report_bad("right", rsp_box_right, want.right);
            if (rsp_box_bottom !== want.bottom)
               report_bad("bottom", rsp_box_bottom, want.bottom);
         end
      end
   end

   initial begin
      logic [CFG_W-1:0] area;
      arm_type          a;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_elbow_x      = '0;
      req_elbow_y      = '0;
      req_wrist_x      = '0;
      req_wrist_y      = '0;
      req_elbow_vis    = '0;
      req_wrist_vis    = '0;
      req_image_width  = '0;
      req_image_height = '0;
      csr_valid        = 1'b0;
      csr_min_area     = '0;
      min_area_now     = MIN_AREA_RESET;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_DIR; i++)
         send_arm(DIR_ROWS[i].arm,
                  DIR_ROWS[i].typed ? DIR_ROWS[i].want : predict_box(DIR_ROWS[i].arm));

      for (int p = 0; p < 6; p++) begin
         // drain before touching min_area
         req_valid = 1'b0;
         wait (pending_boxes.size() == 0);
         @(negedge clock);
         case (p)
            0: begin area = '0; snd_burst = 1'b0; rsp_burst = 1'b0; end
            1: begin area = CFG_W'($urandom_range(0, 40000)); snd_burst = 1'b1;
                  rsp_burst = 1'b1; end
            2: begin area = MIN_AREA_RESET; snd_burst = 1'b1; rsp_burst = 1'b0; end
            3: begin area = CFG_W'(4194304); snd_burst = 1'b0; rsp_burst = 1'b0; end
            4: begin area = '1; snd_burst = 1'b0; rsp_burst = 1'b1; end
            default: begin area = CFG_W'($urandom_range(0, 3000)); snd_burst = 1'b0;
                  rsp_burst = 1'b0; end
         endcase
         write_min_area(area);
         for (int n = 0; n < 90; n++) begin
            if (p == 2 && n == 20) begin
               // hold the result side long enough to back up the whole pipe
               req_valid = 1'b0;
               hold_req  = 1'b1;
               @(negedge clock);
            end
            a = draw_arm();
            send_arm(a, predict_box(a));
         end
      end

      req_valid = 1'b0;
      wait (pending_boxes.size() == 0);
      repeat (20) @(posedge clock);
      if (box_errors == 0) begin
         $display("tb_hand_box_from_arm_joints: PASS");
      end else begin
         $display("tb_hand_box_from_arm_joints: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_hand_box_from_arm_joints: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/hbox_pkg.sv
hw/rtl/hand_box_from_arm_joints.sv
test/tb_hand_box_from_arm_joints.sv
